[src/miller_rabin_prime_test_macros.svh]
// Assertion macros shared by the prime test modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef MILLER_RABIN_PRIME_TEST_MACROS_SVH
`define MILLER_RABIN_PRIME_TEST_MACROS_SVH

// Same-cycle implication.
`define MRPT_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MRPT_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/mrpt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrpt_pkg
// Types, constants and base tables for the Miller-Rabin prime test.
// ----------------------------------------------------------------------------
package mrpt_pkg;

    localparam int SW = 6;   // width of the power-of-two exponent and its counter

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_CLASS,
        ST_WIT_INIT,
        ST_POW_CHK,
        ST_MUL_RB,
        ST_WAIT_RB,
        ST_MUL_BB,
        ST_WAIT_BB,
        ST_SQ_INIT,
        ST_SQ_CHK,
        ST_MUL_XX,
        ST_WAIT_XX,
        ST_NEXT_BASE,
        ST_DONE_P,
        ST_DONE_C
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_PREP,
        OP_WIT_INIT,
        OP_MUL,
        OP_SQ_INIT,
        OP_NEXT_BASE
    } dp_op_t;

    typedef enum logic [1:0] {
        MUL_RB,   // r = r * b
        MUL_BB,   // b = b * b, then halve the exponent
        MUL_XX    // y = x * x, x = y
    } mul_sel_t;

    typedef struct packed {
        dp_op_t   op;
        mul_sel_t sel;
    } cmd_t;

    typedef struct packed {
        logic prep_done;
        logic lt2;
        logic is23;
        logic even;
        logic div3;
        logic e_zero;
        logic e_lsb;
        logic k_eq_s;
        logic y_is_one;
        logic mul_done;
        logic sq_fail;
        logic last_base;
    } status_t;

    localparam logic [63:0] THR_A = 64'd1373653;
    localparam logic [63:0] THR_B = 64'd9080191;
    localparam logic [63:0] THR_C = 64'd4759123141;
    localparam logic [63:0] THR_D = 64'd1122004669633;
    localparam logic [63:0] THR_E = 64'd2152302898747;
    localparam logic [63:0] THR_F = 64'd3474749660383;

    localparam logic [20:0] BASE_TAB [0:6][0:11] = '{
        '{21'd2, 21'd3, 21'd0, 21'd0, 21'd0, 21'd0,
          21'd0, 21'd0, 21'd0, 21'd0, 21'd0, 21'd0},
        '{21'd31, 21'd73, 21'd0, 21'd0, 21'd0, 21'd0,
          21'd0, 21'd0, 21'd0, 21'd0, 21'd0, 21'd0},
        '{21'd2, 21'd7, 21'd61, 21'd0, 21'd0, 21'd0,
          21'd0, 21'd0, 21'd0, 21'd0, 21'd0, 21'd0},
        '{21'd2, 21'd13, 21'd23, 21'd1662803, 21'd0, 21'd0,
          21'd0, 21'd0, 21'd0, 21'd0, 21'd0, 21'd0},
        '{21'd2, 21'd3, 21'd5, 21'd7, 21'd11, 21'd0,
          21'd0, 21'd0, 21'd0, 21'd0, 21'd0, 21'd0},
        '{21'd2, 21'd3, 21'd5, 21'd7, 21'd11, 21'd13,
          21'd0, 21'd0, 21'd0, 21'd0, 21'd0, 21'd0},
        '{21'd2, 21'd3, 21'd5, 21'd7, 21'd11, 21'd13,
          21'd17, 21'd19, 21'd23, 21'd29, 21'd31, 21'd37}
    };

    localparam logic [3:0] BASE_CNT [0:6] = '{
        4'd2, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd12
    };

    // Picks the base set from the size of the candidate.
    function automatic logic [2:0] base_set(input logic [63:0] nn);
        logic [2:0] sel;
        if (nn < THR_A)      sel = 3'd0;
        else if (nn < THR_B) sel = 3'd1;
        else if (nn < THR_C) sel = 3'd2;
        else if (nn < THR_D) sel = 3'd3;
        else if (nn < THR_E) sel = 3'd4;
        else if (nn < THR_F) sel = 3'd5;
        else                 sel = 3'd6;
        return sel;
    endfunction

endpackage

[src/mrpt_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrpt_datapath
// Operand registers, decomposition of n-1 and the shift-and-add modular
// multiplier of the prime test.
// ----------------------------------------------------------------------------
`include "miller_rabin_prime_test_macros.svh"

module mrpt_datapath
    import mrpt_pkg::*;
#(
    parameter int NUMBER_BITS = 63
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [NUMBER_BITS-1:0] candidate,
    input  cmd_t                   cmd,
    output status_t                status
);

    localparam int W = NUMBER_BITS;

    logic [W-1:0]  n_reg, n_next;
    logic [W-1:0]  d_reg, d_next;
    logic [W-1:0]  t_reg, t_next;
    logic [1:0]    r3_reg, r3_next;
    logic [SW-1:0] s_reg, s_next;
    logic [SW-1:0] k_reg, k_next;
    logic [2:0]    set_reg, set_next;
    logic [3:0]    bidx_reg, bidx_next;
    logic [W-1:0]  e_reg, e_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  b_reg, b_next;
    logic [W-1:0]  x_reg, x_next;
    logic [W-1:0]  y_reg, y_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  mx_reg, mx_next;
    logic [W-1:0]  my_reg, my_next;
    mul_sel_t      dst_reg, dst_next;
    logic          busy_reg, busy_next;

    logic [W-1:0]  acc_sum;
    logic [W-1:0]  mx_dbl;
    logic          mul_done;

    // (a + b) mod m for a, b < m.
    function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                             input logic [W-1:0] m);
        logic [W:0] t;
        t = {1'b0, a} + {1'b0, b};
        if (t >= {1'b0, m})
            t = t - {1'b0, m};
        return t[W-1:0];
    endfunction

    // Running residue mod 3 of a base-4 digit stream (4 is 1 mod 3).
    function automatic logic [1:0] mod3_step(input logic [1:0] r, input logic [1:0] dg);
        logic [2:0] t;
        t = {1'b0, r} + {1'b0, dg};
        if (t >= 3'd3)
            t = t - 3'd3;
        return t[1:0];
    endfunction

    assign acc_sum  = add_mod(acc_reg, mx_reg, n_reg);
    assign mx_dbl   = add_mod(mx_reg, mx_reg, n_reg);
    assign mul_done = busy_reg && (my_reg == '0);

    always_comb
    begin
        n_next    = n_reg;
        d_next    = d_reg;
        t_next    = t_reg;
        r3_next   = r3_reg;
        s_next    = s_reg;
        k_next    = k_reg;
        set_next  = set_reg;
        bidx_next = bidx_reg;
        e_next    = e_reg;
        r_next    = r_reg;
        b_next    = b_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        mx_next   = mx_reg;
        my_next   = my_reg;
        dst_next  = dst_reg;
        busy_next = busy_reg;

        case (cmd.op)
            OP_LOAD:
            begin
                n_next    = candidate;
                t_next    = candidate;
                d_next    = candidate >> 1;
                s_next    = SW'(1);
                r3_next   = 2'd0;
                bidx_next = 4'd0;
            end
            OP_PREP:
            begin
                if (t_reg != '0)
                begin
                    r3_next = mod3_step(r3_reg, t_reg[1:0]);
                    t_next  = t_reg >> 2;
                end
                if (d_reg != '0 && !d_reg[0])
                begin
                    d_next = d_reg >> 1;
                    s_next = s_reg + SW'(1);
                end
                set_next = base_set(64'(n_reg));
            end
            OP_WIT_INIT:
            begin
                r_next = W'(1);
                b_next = W'(BASE_TAB[set_reg][bidx_reg]);
                e_next = d_reg;
            end
            OP_MUL:
            begin
                busy_next = 1'b1;
                acc_next  = '0;
                dst_next  = cmd.sel;
                case (cmd.sel)
                    MUL_RB:
                    begin
                        mx_next = r_reg;
                        my_next = b_reg;
                    end
                    MUL_BB:
                    begin
                        mx_next = b_reg;
                        my_next = b_reg;
                    end
                    default:
                    begin
                        mx_next = x_reg;
                        my_next = x_reg;
                    end
                endcase
            end
            OP_SQ_INIT:
            begin
                x_next = r_reg;
                y_next = r_reg;
                k_next = '0;
            end
            OP_NEXT_BASE:
            begin
                bidx_next = bidx_reg + 4'd1;
            end
            default:
            begin
            end
        endcase

        // One multiplier bit per cycle while busy.
        if (busy_reg)
        begin
            if (my_reg != '0)
            begin
                if (my_reg[0])
                    acc_next = acc_sum;
                mx_next = mx_dbl;
                my_next = my_reg >> 1;
            end
            else
            begin
                busy_next = 1'b0;
                case (dst_reg)
                    MUL_RB:
                    begin
                        r_next = acc_reg;
                    end
                    MUL_BB:
                    begin
                        b_next = acc_reg;
                        e_next = e_reg >> 1;
                    end
                    default:
                    begin
                        y_next = acc_reg;
                        x_next = acc_reg;
                        k_next = k_reg + SW'(1);
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        d_reg    <= d_next;
        t_reg    <= t_next;
        r3_reg   <= r3_next;
        s_reg    <= s_next;
        k_reg    <= k_next;
        set_reg  <= set_next;
        bidx_reg <= bidx_next;
        e_reg    <= e_next;
        r_reg    <= r_next;
        b_reg    <= b_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        acc_reg  <= acc_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        dst_reg  <= dst_next;
    end

    always_comb
    begin
        status.prep_done = (t_reg == '0) && ((d_reg == '0) || d_reg[0]);
        status.lt2       = (n_reg < W'(2));
        status.is23      = (n_reg == W'(2)) || (n_reg == W'(3));
        status.even      = !n_reg[0];
        status.div3      = (r3_reg == 2'd0);
        status.e_zero    = (e_reg == '0);
        status.e_lsb     = e_reg[0];
        status.k_eq_s    = (k_reg == s_reg);
        status.y_is_one  = (y_reg == W'(1));
        status.mul_done  = mul_done;
        status.sq_fail   = (acc_reg == W'(1)) && (x_reg != W'(1))
                           && (x_reg != n_reg - W'(1));
        status.last_base = ((bidx_reg + 4'd1) == BASE_CNT[set_reg]);
    end

    `MRPT_CHECK(a_mul_idle_start, cmd.op == OP_MUL, !busy_reg,
                "multiply started while the multiplier is busy")
    `MRPT_CHECK_NEXT(a_mul_finish, mul_done, !busy_reg,
                     "multiplier stayed busy after its last bit")
    `MRPT_CHECK(a_mul_reduced, busy_reg, (acc_reg < n_reg) && (mx_reg < n_reg),
                "multiplier operands left the residue range")

endmodule

[src/mrpt_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrpt_ctrl
// Sequencer of the prime test and holder of the result register.
// ----------------------------------------------------------------------------
`include "miller_rabin_prime_test_macros.svh"

module mrpt_ctrl
    import mrpt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output logic    out_prime,
    output cmd_t    cmd,
    input  status_t status
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   prime_reg, prime_next;
    logic   slot_free;
    logic   fin;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (in_valid) state_next = ST_PREP;
            ST_PREP:      if (status.prep_done) state_next = ST_CLASS;
            ST_CLASS:
            begin
                if (status.lt2)
                    state_next = ST_DONE_C;
                else if (status.is23)
                    state_next = ST_DONE_P;
                else if (status.even || status.div3)
                    state_next = ST_DONE_C;
                else
                    state_next = ST_WIT_INIT;
            end
            ST_WIT_INIT:  state_next = ST_POW_CHK;
            ST_POW_CHK:
            begin
                if (status.e_zero)
                    state_next = ST_SQ_INIT;
                else if (status.e_lsb)
                    state_next = ST_MUL_RB;
                else
                    state_next = ST_MUL_BB;
            end
            ST_MUL_RB:    state_next = ST_WAIT_RB;
            ST_WAIT_RB:   if (status.mul_done) state_next = ST_MUL_BB;
            ST_MUL_BB:    state_next = ST_WAIT_BB;
            ST_WAIT_BB:   if (status.mul_done) state_next = ST_POW_CHK;
            ST_SQ_INIT:   state_next = ST_SQ_CHK;
            ST_SQ_CHK:
            begin
                if (!status.k_eq_s)
                    state_next = ST_MUL_XX;
                else if (status.y_is_one)
                    state_next = ST_NEXT_BASE;
                else
                    state_next = ST_DONE_C;
            end
            ST_MUL_XX:    state_next = ST_WAIT_XX;
            ST_WAIT_XX:
            begin
                if (status.mul_done)
                    state_next = status.sq_fail ? ST_DONE_C : ST_SQ_CHK;
            end
            ST_NEXT_BASE: state_next = status.last_base ? ST_DONE_P : ST_WIT_INIT;
            ST_DONE_P:    if (slot_free) state_next = ST_IDLE;
            ST_DONE_C:    if (slot_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op   = OP_NONE;
        cmd.sel  = MUL_RB;
        in_ready = 1'b0;
        fin      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    cmd.op = OP_LOAD;
            end
            ST_PREP:      cmd.op = OP_PREP;
            ST_WIT_INIT:  cmd.op = OP_WIT_INIT;
            ST_MUL_RB:
            begin
                cmd.op  = OP_MUL;
                cmd.sel = MUL_RB;
            end
            ST_MUL_BB:
            begin
                cmd.op  = OP_MUL;
                cmd.sel = MUL_BB;
            end
            ST_MUL_XX:
            begin
                cmd.op  = OP_MUL;
                cmd.sel = MUL_XX;
            end
            ST_SQ_INIT:   cmd.op = OP_SQ_INIT;
            ST_NEXT_BASE: if (!status.last_base) cmd.op = OP_NEXT_BASE;
            ST_DONE_P:    fin = slot_free;
            ST_DONE_C:    fin = slot_free;
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        prime_next     = prime_reg;
        if (fin)
        begin
            out_valid_next = 1'b1;
            prime_next     = (state_reg == ST_DONE_P);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prime_reg <= prime_next;
    end

    assign out_valid = out_valid_reg;
    assign out_prime = prime_reg;

    `MRPT_CHECK_NEXT(a_accept_prep, in_valid && in_ready, state_reg == ST_PREP,
                     "accepted request did not start preparation")
    `MRPT_CHECK_NEXT(a_fin_valid, fin, out_valid_reg,
                     "finished request did not reach the output register")
    `MRPT_CHECK_NEXT(a_out_hold, out_valid_reg && !out_ready, out_valid_reg,
                     "waiting result was dropped before it was taken")

endmodule

[src/miller_rabin_prime_test.sv]
`timescale 1ns / 1ps
// Operation: the block first splits n-1 and reduces n mod 3, then runs for each
// witness base (up to twelve) roughly (2*bitlen(d) + s) modular multiplications.
// Each multiplication runs in the single shift-and-add multiplier, bit by bit.
// Requests are handled one at a time; a new request is taken once the last one is done.
// Reset (rst_n, asynchronous, active low) clears the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
// miller_rabin_prime_test
// Deterministic Miller-Rabin primality test over streaming request/result ports.
// ----------------------------------------------------------------------------
//
// The sequencer (mrpt_ctrl) walks through the test and drives the datapath
// (mrpt_datapath) with one command per cycle. The datapath keeps n, the odd
// part d of n-1 and its power-of-two count s, the witness registers and one
// modular multiplier that adds one partial product per cycle, reducing after
// every addition so that all values stay below n.
//
// Small cases (below two, two and three, even numbers and multiples of three)
// are settled straight after preparation. Otherwise the base set is chosen by
// comparing n against six thresholds, and each base runs a right-to-left
// square-and-multiply for a^d followed by s squarings. A witness fails when a
// nontrivial square root of one appears or the last square is not one.
//
// The result sits in an output register, so a finished request waits there
// while the block is already idle for the next one.

module miller_rabin_prime_test
    import mrpt_pkg::*;
#(
    parameter int NUMBER_BITS = 63
)(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // Fields from bit 0 up: candidate [NUMBER_BITS-1:0], zero padding above.
    input  logic [((NUMBER_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // Fields from bit 0 up: is_prime [0], zero padding above.
    output logic [7:0]                            m_axis_tdata
);

    cmd_t    cmd;
    status_t status;
    logic    is_prime;

    mrpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_prime (is_prime),
        .cmd       (cmd),
        .status    (status)
    );

    // Padding bits above the candidate are ignored.
    mrpt_datapath #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .candidate (s_axis_tdata[NUMBER_BITS-1:0]),
        .cmd       (cmd),
        .status    (status)
    );

    assign m_axis_tdata = {7'd0, is_prime};

endmodule

[sim/tb_miller_rabin_prime_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_miller_rabin_prime_test
// Self-checking testbench for the streaming Miller-Rabin prime test.
// ----------------------------------------------------------------------------
//
// Each accepted request is run through a behavioural primality predictor and
// its answer is queued. A separate process takes every result from the block
// and compares it with the oldest queued answer. A directed test covers the
// small cases, the base-set thresholds, known strong pseudoprimes and the ends
// of the candidate range. A random test follows. Most random candidates are
// small, because the block's run time grows steeply with the candidate width.
// Both sides of the stream insert random idle cycles.

module tb_miller_rabin_prime_test;

    localparam int NB         = 63;
    localparam int TDW        = ((NB + 7) / 8) * 8;
    localparam int IDLE_LIMIT = 400000;

    logic           clk;
    logic           rst_n;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    logic [TDW-1:0] s_axis_tdata;
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    logic [7:0]     m_axis_tdata;

    // Answers still owed by the block, oldest first.
    bit   verdict_q [$];
    int   mismatches;
    // When set, neither side inserts idle cycles.
    bit   no_idle;
    int   idle_cycles;

    miller_rabin_prime_test #(
        .NUMBER_BITS(NB)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // ------------------------------------------------------------------
    // Primality predictor. Products are formed at full double width, so the
    // reduction is exact for any modulus below 2^63.
    // ------------------------------------------------------------------
    function automatic logic [63:0] mul_mod_n(logic [63:0] a, logic [63:0] b,
                                              logic [63:0] m);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return 64'(p % {64'd0, m});
    endfunction

    function automatic logic [63:0] pow_mod_n(logic [63:0] b, logic [63:0] e,
                                              logic [63:0] m);
        logic [63:0] r;
        r = 64'd1 % m;
        b = b % m;
        while (e != 0)
        begin
            if (e[0])
                r = mul_mod_n(r, b, m);
            b = mul_mod_n(b, b, m);
            e = e >> 1;
        end
        return r;
    endfunction

    // True when base a does not prove n composite.
    function automatic bit witness_holds(logic [63:0] n, int s, logic [63:0] d,
                                         logic [63:0] a);
        logic [63:0] x;
        logic [63:0] y;
        x = pow_mod_n(a, d, n);
        y = x;
        for (int k = 0; k < s; k++)
        begin
            y = mul_mod_n(x, x, n);
            if (y == 1 && x != 1 && x != n - 1)
                return 1'b0;
            x = y;
        end
        return y == 1;
    endfunction

    function automatic bit prime_verdict(logic [NB-1:0] cand);
        logic [63:0] n;
        logic [63:0] d;
        logic [63:0] bases [12];
        int          s;
        int          cnt;
        n = 64'(cand);
        if (n < 2)
            return 1'b0;
        if (n == 2 || n == 3)
            return 1'b1;
        if (!n[0] || n % 3 == 0)
            return 1'b0;
        d = n >> 1;
        s = 1;
        while (d != 0 && !d[0])
        begin
            d = d >> 1;
            s++;
        end
        // The base set depends on which of the six thresholds n lies below.
        if (n < 64'd1373653)
        begin
            bases[0:1] = '{64'd2, 64'd3};
            cnt = 2;
        end
        else if (n < 64'd9080191)
        begin
            bases[0:1] = '{64'd31, 64'd73};
            cnt = 2;
        end
        else if (n < 64'd4759123141)
        begin
            bases[0:2] = '{64'd2, 64'd7, 64'd61};
            cnt = 3;
        end
        else if (n < 64'd1122004669633)
        begin
            bases[0:3] = '{64'd2, 64'd13, 64'd23, 64'd1662803};
            cnt = 4;
        end
        else if (n < 64'd2152302898747)
        begin
            bases[0:4] = '{64'd2, 64'd3, 64'd5, 64'd7, 64'd11};
            cnt = 5;
        end
        else if (n < 64'd3474749660383)
        begin
            bases[0:5] = '{64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd13};
            cnt = 6;
        end
        else
        begin
            bases = '{64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd13,
                      64'd17, 64'd19, 64'd23, 64'd29, 64'd31, 64'd37};
            cnt = 12;
        end
        for (int i = 0; i < cnt; i++)
            if (!witness_holds(n, s, d, bases[i]))
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // Sends one candidate. Called at a rising edge; returns at the edge on
    // which the request is taken, leaving tvalid high so that a following
    // request without a gap needs no second assignment in that step.
    task automatic send_candidate(logic [NB-1:0] cand);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDW'(cand);
        do
            @(posedge clk);
        while (!s_axis_tready);
        verdict_q.push_back(prime_verdict(cand));
    endtask

    // Result side: random back-pressure, then compare with the oldest answer.
    initial
    begin
        int stall;
        bit want;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            if (verdict_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %0d", m_axis_tdata[0]));
            end
            else
            begin
                want = verdict_q.pop_front();
                if (m_axis_tdata[0] !== want)
                    report_mismatch($sformatf("is_prime %0b, predicted %0b",
                                              m_axis_tdata[0], want));
            end
        end
    end

    // Watchdog: a long run of cycles with no request or result taken ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Small cases, threshold edges, strong pseudoprimes and the range ends.
    task automatic test_directed();
        logic [NB-1:0] vals [$];
        vals = '{63'd0, 63'd1, 63'd2, 63'd3, 63'd4, 63'd9, 63'd5, 63'd25, 63'd561,
                 63'd1373653, 63'd1373651, 63'd9080191, 63'd9080189,
                 63'd3215031751, 63'd4759123141, 63'd1122004669633,
                 63'd2152302898747, 63'd3474749660383, 63'd341550071728321,
                 63'h7FFFFFFFFFFFFFFF, 63'd9223372036854775783};
        foreach (vals[i])
            send_candidate(vals[i]);
    endtask

    task automatic test_random();
        logic [NB-1:0] cand;
        int            sel;
        int            width;
        for (int i = 0; i < 80; i++)
        begin
            // A burst without idle cycles on either side, then idling again.
            no_idle = (i >= 30 && i < 45);
            // Once, hold off until the block has answered everything.
            if (i == 60)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                wait (verdict_q.size() == 0);
            end
            sel = $urandom_range(0, 99);
            if (sel < 88)
                width = $urandom_range(2, 24);
            else if (sel < 98)
                width = $urandom_range(25, 36);
            else
                width = NB;
            cand = NB'({$urandom, $urandom}) & ((NB'(1) << width) - 1);
            if (width == NB)
                cand = NB'({$urandom, $urandom});
            // Mostly odd candidates, so that the witness loop actually runs.
            if ($urandom_range(0, 9) < 8)
                cand[0] = 1'b1;
            send_candidate(cand);
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        mismatches    = 0;
        no_idle       = 1'b0;
        idle_cycles   = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random();

        s_axis_tvalid <= 1'b0;
        wait (verdict_q.size() == 0);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
